/* rtl/triangle_tangent_frame_core_macros.svh */
// Assertion macros for the triangle tangent frame core.
`ifndef TRIANGLE_TANGENT_FRAME_CORE_MACROS_SVH
`define TRIANGLE_TANGENT_FRAME_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TTF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TTF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/ttf_pkg.sv */
// Shared types, constants and unit operation codes for the tangent frame core.
package ttf_pkg;
    localparam int unsigned POS_W_DEF = 24;
    localparam int unsigned UV_W_DEF  = 16;
    localparam int unsigned OUT_W_DEF = 16;
    localparam int unsigned NORM_BITS = 30;

    typedef enum logic [2:0] {
        OP_MUL = 3'b001,
        OP_SQRT = 3'b010,
        OP_DIV = 3'b100
    } t_op;

    typedef struct packed {
        logic  start;
        t_op   op;
    } t_unit_ctl;
endpackage

/* rtl/ttf_unit.sv */
// Shared iterative unit: multiply, square root and divide over 64-bit operands.
module ttf_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttf_pkg::t_unit_ctl i_ctl,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    output logic              o_done,
    output logic [63:0]       o_res
);
    import ttf_pkg::*;

    logic [63:0]  r_acc, n_acc;
    logic [63:0]  r_x, n_x;
    logic [63:0]  r_y, n_y;
    logic [63:0]  r_bit, n_bit;
    logic [6:0]   r_cnt, n_cnt;
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    t_op          r_op, n_op;
    logic [64:0]  w_trial;
    logic [63:0]  w_rb;

    assign w_rb    = r_acc + r_bit;
    assign w_trial = {1'b0, r_x} - {1'b0, (r_op == OP_DIV) ? r_y : w_rb};
    assign o_done  = r_done;

    always_comb begin
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_bit  = r_bit;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_op   = r_op;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_acc  = '0;
            n_x    = i_a;
            n_y    = i_b;
            n_bit  = 64'h4000_0000_0000_0000;
            n_cnt  = (i_ctl.op == OP_SQRT) ? 7'd32 : 7'd64;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    if (r_y[0]) n_acc = r_acc + r_x;
                    n_x = r_x << 1;
                    n_y = r_y >> 1;
                end
                OP_SQRT: begin
                    if (!w_trial[64]) begin
                        n_x   = w_trial[63:0];
                        n_acc = (r_acc >> 1) + r_bit;
                    end else begin
                        n_acc = r_acc >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
                OP_DIV: begin
                    // shift-subtract: r_acc is remainder, r_x the quotient bits
                    n_acc = {r_acc[62:0], r_x[63]};
                    n_x   = {r_x[62:0], 1'b0};
                    if ({r_acc[62:0], r_x[63]} >= r_y) begin
                        n_acc = {r_acc[62:0], r_x[63]} - r_y;
                        n_x[0] = 1'b1;
                    end
                end
                default: n_busy = 1'b0;
            endcase
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_comb begin
        case (r_op)
            OP_DIV:  o_res = r_x;
            default: o_res = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_bit <= n_bit;
    end
endmodule

/* rtl/ttf_seq.sv */
// Sequencer: vertex holding, edge and cross terms, normalization through the unit.
module ttf_seq #(
    parameter int unsigned POS_WIDTH = ttf_pkg::POS_W_DEF,
    parameter int unsigned UV_WIDTH  = ttf_pkg::UV_W_DEF,
    parameter int unsigned OUT_WIDTH = ttf_pkg::OUT_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [POS_WIDTH-1:0] i_p [3],
    input  logic signed [UV_WIDTH-1:0]  i_u,
    input  logic signed [UV_WIDTH-1:0]  i_v,
    input  logic                        i_first,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [OUT_WIDTH-1:0]        o_t [3],
    output logic [OUT_WIDTH-1:0]        o_b [3],
    output logic                        o_degen
);
    import ttf_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL   = 10'b00_0000_0010,
        S_MWAIT = 10'b00_0000_0100,
        S_PREP  = 10'b00_0000_1000,
        S_SQ    = 10'b00_0001_0000,
        S_SQW   = 10'b00_0010_0000,
        S_SQRT  = 10'b00_0100_0000,
        S_DIV   = 10'b00_1000_0000,
        S_DWAIT = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_st, n_st;
    logic [1:0] r_cnt;
    logic signed [POS_WIDTH-1:0] r_hp [6];
    logic signed [UV_WIDTH-1:0]  r_hu [4];
    logic signed [POS_WIDTH:0]   r_e1 [3];
    logic signed [POS_WIDTH:0]   r_e2 [3];
    logic signed [UV_WIDTH:0]    r_du1, r_dv1, r_du2, r_dv2;
    // products: 0..5 T terms, 6..11 B terms, 12..13 det terms
    logic signed [63:0] r_pr [14];
    logic [3:0]  r_mi;
    logic signed [63:0] r_c [6];
    logic        r_neg;
    logic        r_bad;
    logic        r_vec;
    logic [63:0] r_a [3];
    logic [63:0] r_sum;
    logic [63:0] r_len;
    logic [1:0]  r_di;
    logic [OUT_WIDTH-1:0] r_t [3];
    logic [OUT_WIDTH-1:0] r_b [3];
    logic        r_ov;

    t_unit_ctl   w_ctl;
    logic [63:0] w_ua, w_ub, w_ures;
    logic        w_udone;
    logic signed [63:0] w_ma, w_mb;
    logic [63:0] w_mag [3];
    logic [63:0] w_mx;
    logic [5:0]  w_s;
    logic [63:0] w_q;
    logic [OUT_WIDTH-1:0] w_qs;
    logic        w_ng;

    ttf_unit u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_a    (w_ua),
        .i_b    (w_ub),
        .o_done (w_udone),
        .o_res  (w_ures)
    );

    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_t = r_t;
    assign o_b = r_b;
    assign o_degen = r_bad;

    always_comb begin
        case (r_mi)
            4'd0:  begin w_ma = 64'(r_dv2); w_mb = 64'(r_e1[0]); end
            4'd1:  begin w_ma = 64'(r_dv1); w_mb = 64'(r_e2[0]); end
            4'd2:  begin w_ma = 64'(r_dv2); w_mb = 64'(r_e1[1]); end
            4'd3:  begin w_ma = 64'(r_dv1); w_mb = 64'(r_e2[1]); end
            4'd4:  begin w_ma = 64'(r_dv2); w_mb = 64'(r_e1[2]); end
            4'd5:  begin w_ma = 64'(r_dv1); w_mb = 64'(r_e2[2]); end
            4'd6:  begin w_ma = 64'(r_du1); w_mb = 64'(r_e2[0]); end
            4'd7:  begin w_ma = 64'(r_du2); w_mb = 64'(r_e1[0]); end
            4'd8:  begin w_ma = 64'(r_du1); w_mb = 64'(r_e2[1]); end
            4'd9:  begin w_ma = 64'(r_du2); w_mb = 64'(r_e1[1]); end
            4'd10: begin w_ma = 64'(r_du1); w_mb = 64'(r_e2[2]); end
            4'd11: begin w_ma = 64'(r_du2); w_mb = 64'(r_e1[2]); end
            4'd12: begin w_ma = 64'(r_du1); w_mb = 64'(r_dv2); end
            default: begin w_ma = 64'(r_du2); w_mb = 64'(r_dv1); end
        endcase
    end

    // magnitudes of the current vector and the pre-shift
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_c[(r_vec ? 3 : 0) + i][63] ? 64'(-r_c[(r_vec ? 3 : 0) + i])
                                                    : 64'(r_c[(r_vec ? 3 : 0) + i]);
        end
        w_mx = (w_mag[0] > w_mag[1]) ? w_mag[0] : w_mag[1];
        w_mx = (w_mx > w_mag[2]) ? w_mx : w_mag[2];
        w_s = '0;
        for (int k = 63; k >= NORM_BITS; k--) begin
            if (w_mx[k] && w_s == '0) w_s = 6'(k - NORM_BITS + 1);
        end
    end

    assign w_q  = w_ures;
    assign w_ng = r_c[(r_vec ? 3 : 0) + 32'(r_di)][63] != r_neg;
    assign w_qs = w_ng ? OUT_WIDTH'(-w_q) : OUT_WIDTH'(w_q);

    always_comb begin
        w_ctl.start = 1'b0;
        w_ctl.op    = OP_MUL;
        w_ua = '0;
        w_ub = '0;
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (i_valid && !r_ov && !i_first && r_cnt == 2'd2 && i_en) n_st = S_MUL;
            end
            S_MUL: begin
                w_ctl.start = 1'b1;
                w_ctl.op    = OP_MUL;
                w_ua = w_ma;
                w_ub = w_mb;
                n_st = S_MWAIT;
            end
            S_MWAIT: begin
                if (w_udone) begin
                    if (r_mi != 4'd13) n_st = S_MUL;
                    else if (r_pr[12] == $signed(w_ures)) n_st = S_OUT;
                    else n_st = S_PREP;
                end
            end
            S_PREP: n_st = S_SQ;
            S_SQ: begin
                w_ctl.start = 1'b1;
                w_ctl.op    = OP_MUL;
                w_ua = r_a[r_di];
                w_ub = r_a[r_di];
                n_st = S_SQW;
            end
            S_SQW: begin
                if (w_udone) begin
                    if (r_di == 2'd2) begin
                        w_ctl.start = 1'b1;
                        w_ctl.op    = OP_SQRT;
                        w_ua = r_sum + w_ures;
                        n_st = S_SQRT;
                    end else begin
                        n_st = S_SQ;
                    end
                end
            end
            S_SQRT: if (w_udone) n_st = (w_ures == '0) ? S_OUT : S_DIV;
            S_DIV: begin
                w_ctl.start = 1'b1;
                w_ctl.op    = OP_DIV;
                w_ua = (r_a[r_di] << (OUT_WIDTH - 2)) + (r_len >> 1);
                w_ub = r_len;
                n_st = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_udone) begin
                    if (r_di != 2'd2) n_st = S_DIV;
                    else if (r_vec) n_st = S_OUT;
                    else n_st = S_PREP;
                end
            end
            S_OUT: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_OUT) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            if (r_st == S_IDLE && i_valid && !r_ov) begin
                if (i_first) r_cnt <= 2'd1;
                else if (r_cnt != 2'd2) r_cnt <= r_cnt + 2'd1;
                else r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid && !r_ov) begin
            if (i_first || r_cnt != 2'd2) begin
                for (int i = 0; i < 3; i++)
                    r_hp[(i_first ? 0 : 3 * 32'(r_cnt)) + i] <= i_p[i];
                r_hu[i_first ? 0 : 2 * 32'(r_cnt)]     <= i_u;
                r_hu[(i_first ? 0 : 2 * 32'(r_cnt)) + 1] <= i_v;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= (POS_WIDTH+1)'(r_hp[3+i]) - (POS_WIDTH+1)'(r_hp[i]);
                    r_e2[i] <= (POS_WIDTH+1)'(i_p[i]) - (POS_WIDTH+1)'(r_hp[i]);
                end
                r_du1 <= (UV_WIDTH+1)'(r_hu[2]) - (UV_WIDTH+1)'(r_hu[0]);
                r_dv1 <= (UV_WIDTH+1)'(r_hu[3]) - (UV_WIDTH+1)'(r_hu[1]);
                r_du2 <= (UV_WIDTH+1)'(i_u) - (UV_WIDTH+1)'(r_hu[0]);
                r_dv2 <= (UV_WIDTH+1)'(i_v) - (UV_WIDTH+1)'(r_hu[1]);
                r_mi  <= '0;
                r_vec <= 1'b0;
                r_bad <= 1'b0;
            end
        end
        if (r_st == S_MWAIT && w_udone) begin
            r_pr[r_mi] <= $signed(w_ures);
            r_mi <= r_mi + 4'd1;
            if (r_mi == 4'd13) begin
                for (int i = 0; i < 3; i++) begin
                    r_c[i]   <= r_pr[2*i] - r_pr[2*i+1];
                    r_c[3+i] <= r_pr[6+2*i] - r_pr[7+2*i];
                end
                r_neg <= (r_pr[12] - $signed(w_ures)) < 0;
                r_bad <= (r_pr[12] == $signed(w_ures));
                r_vec <= 1'b0;
            end
        end
        if (r_st == S_PREP) begin
            for (int i = 0; i < 3; i++) r_a[i] <= w_mag[i] >> w_s;
            r_sum <= '0;
            r_di  <= '0;
        end
        if (r_st == S_SQW && w_udone) begin
            r_sum <= r_sum + w_ures;
            r_di  <= r_di + 2'd1;
        end
        if (r_st == S_SQRT && w_udone) begin
            r_len <= w_ures;
            r_di  <= '0;
            if (w_ures == '0) r_bad <= 1'b1;
        end
        if (r_st == S_DWAIT && w_udone) begin
            if (r_vec) r_b[r_di] <= w_qs;
            else r_t[r_di] <= w_qs;
            r_di <= r_di + 2'd1;
            if (r_di == 2'd2) r_vec <= 1'b1;
        end
    end
endmodule

/* rtl/triangle_tangent_frame_core.sv */
// Operation: a held vertex is stored; with tangent_enable set, a third vertex runs
// 14 multiplies, then per vector three squares, a square root and three divides,
// after which the output item is valid.
// A zero determinant skips the squares, square root and divides.
// Throughput: one item at a time; input stalls until the output item is taken.
// Reset: synchronous active low clears vertex count, sequencer and output
// valid; tangent_enable returns to 1.
module triangle_tangent_frame_core #(
    parameter int unsigned POS_WIDTH = ttf_pkg::POS_W_DEF,
    parameter int unsigned UV_WIDTH  = ttf_pkg::UV_W_DEF,
    parameter int unsigned OUT_WIDTH = ttf_pkg::OUT_W_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
    input  logic [((3*POS_WIDTH+2*UV_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // first_vertex
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tangent_x..z, bitangent_x..z, zero pad
    output logic [((6*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic m_axis_tuser
);
    import ttf_pkg::*;

    logic r_en;
    logic signed [POS_WIDTH-1:0] w_p [3];
    logic [OUT_WIDTH-1:0] w_t [3];
    logic [OUT_WIDTH-1:0] w_b [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_en <= 1'b1;
        else if (i_cfg_we) r_en <= i_cfg_wdata;
    end

    for (genvar i = 0; i < 3; i++) begin : g_p
        assign w_p[i] = s_axis_tdata[i*POS_WIDTH +: POS_WIDTH];
    end

    ttf_seq #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (r_en),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_p    (w_p),
        .i_u    (s_axis_tdata[3*POS_WIDTH +: UV_WIDTH]),
        .i_v    (s_axis_tdata[3*POS_WIDTH+UV_WIDTH +: UV_WIDTH]),
        .i_first(s_axis_tuser),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_t    (w_t),
        .o_b    (w_b),
        .o_degen(m_axis_tuser)
    );

    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            m_axis_tdata[i*OUT_WIDTH +: OUT_WIDTH]     = m_axis_tuser ? '0 : w_t[i];
            m_axis_tdata[(3+i)*OUT_WIDTH +: OUT_WIDTH] = m_axis_tuser ? '0 : w_b[i];
        end
    end
endmodule

/* rtl/ttf_checker.sv */
// Port-level checker for the tangent frame core, bound to the top level.
`include "triangle_tangent_frame_core_macros.svh"
module ttf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tuser
);
    `TTF_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `TTF_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TTF_ASSERT_NXT(a_out_drops, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
endmodule

bind triangle_tangent_frame_core ttf_checker u_ttf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser)
);

/* dv/triangle_tangent_frame_core_tb.sv */
// Testbench for the triangle tangent frame core: vertex stream in, tangent frames checked.
`timescale 1ns / 100ps
module triangle_tangent_frame_core_tb;
    localparam int POS_W = 24;
    localparam int UV_W = 16;
    localparam int OUT_W = 16;
    localparam int IN_DW = ((3*POS_W+2*UV_W+7)/8)*8;
    localparam int OUT_DW = ((6*OUT_W+7)/8)*8;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 3000;

    typedef struct {
        logic signed [POS_W-1:0] px, py, pz;
        logic signed [UV_W-1:0] tu, tv;
        logic first;
    } vertex_t;

    typedef struct {
        logic [OUT_W-1:0] comp[6];
        logic degenerate;
    } frame_t;

    class frame_scoreboard;
        vertex_t held[2];
        int held_count;
        bit enable;
        frame_t pending[$];
        int errors;
        int frames_seen;
        int degenerate_seen;

        function void reset_state();
            held_count = 0;
            enable = 1;
            pending.delete();
        endfunction

        function longint unsigned root64(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function bit unit_vector(longint c[3], bit flip, output logic [OUT_W-1:0] o[3]);
            longint unsigned mag[3], a[3], m, sum, len, q;
            int s;
            m = 0;
            sum = 0;
            s = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = c[i] < 0 ? -c[i] : c[i];
                if (mag[i] > m) m = mag[i];
            end
            while ((m >> s) >= (64'd1 << 30)) s++;
            for (int i = 0; i < 3; i++) begin
                a[i] = mag[i] >> s;
                sum += a[i] * a[i];
            end
            if (sum == 0) return 0;
            len = root64(sum);
            for (int i = 0; i < 3; i++) begin
                q = ((a[i] << (OUT_W-2)) + (len >> 1)) / len;
                o[i] = OUT_W'(((c[i] < 0) != flip) ? -q : q);
            end
            return 1;
        endfunction

        function void note_vertex(vertex_t vx);
            longint e1[3], e2[3], tg[3], bt[3], p0[3], p1[3], p2[3];
            longint du1, dv1, du2, dv2, det;
            logic [OUT_W-1:0] tn[3], bn[3];
            frame_t f;
            bit ok;
            if (vx.first) held_count = 0;
            if (held_count < 2) begin
                held[held_count] = vx;
                held_count++;
                return;
            end
            held_count = 0;
            if (!enable) return;
            p0 = '{held[0].px, held[0].py, held[0].pz};
            p1 = '{held[1].px, held[1].py, held[1].pz};
            p2 = '{vx.px, vx.py, vx.pz};
            for (int i = 0; i < 3; i++) begin
                e1[i] = p1[i] - p0[i];
                e2[i] = p2[i] - p0[i];
            end
            du1 = longint'(held[1].tu) - held[0].tu;
            dv1 = longint'(held[1].tv) - held[0].tv;
            du2 = longint'(vx.tu) - held[0].tu;
            dv2 = longint'(vx.tv) - held[0].tv;
            det = du1 * dv2 - du2 * dv1;
            for (int i = 0; i < 3; i++) begin
                tg[i] = dv2 * e1[i] - dv1 * e2[i];
                bt[i] = du1 * e2[i] - du2 * e1[i];
            end
            ok = det != 0;
            if (ok) ok = unit_vector(tg, det < 0, tn);
            if (ok) ok = unit_vector(bt, det < 0, bn);
            for (int i = 0; i < 3; i++) begin
                f.comp[i] = ok ? tn[i] : '0;
                f.comp[3+i] = ok ? bn[i] : '0;
            end
            f.degenerate = !ok;
            pending = {pending, f};
        endfunction

        function void check_frame(logic [OUT_DW-1:0] data, logic deg);
            frame_t f;
            string names[6];
            names = '{"tangent_x", "tangent_y", "tangent_z",
                      "bitangent_x", "bitangent_y", "bitangent_z"};
            frames_seen++;
            if (deg) degenerate_seen++;
            if (pending.size() == 0) begin
                $error("unexpected frame %h", data);
                errors++;
                return;
            end
            f = pending.pop_front();
            for (int i = 0; i < 6; i++)
                if (data[i*OUT_W +: OUT_W] !== f.comp[i]) begin
                    $error("%s expected %h actual %h", names[i], f.comp[i],
                           data[i*OUT_W +: OUT_W]);
                    errors++;
                end
            if (deg !== f.degenerate) begin
                $error("degenerate expected %0d actual %0d", f.degenerate, deg);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic i_cfg_wdata = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_DW-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic m_axis_tuser;

    frame_scoreboard board = new();
    int cycle_count = 0;
    int long_hold = 0;
    bit sink_random = 0;
    int vertices_sent = 0;

    triangle_tangent_frame_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sink: check on accept, then draw the next ready pattern.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            board.check_frame(m_axis_tdata, m_axis_tuser);
    end

    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (long_hold > 0) begin
                m_axis_tready <= 0;
                long_hold--;
            end else if (!sink_random) begin
                m_axis_tready <= 1;
            end else begin
                gap = $urandom_range(0, 14);
                if (gap == 0 || $urandom_range(0, 3) == 0) begin
                    m_axis_tready <= 1;
                end else begin
                    m_axis_tready <= 0;
                    repeat (gap - 1) @(negedge i_clk);
                    m_axis_tready <= 1;
                end
            end
        end
    end

    task automatic send_vertex(vertex_t vx, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {vx.tv, vx.tu, vx.pz, vx.py, vx.px};
        s_axis_tuser <= vx.first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_vertex(vx);
        vertices_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(bit value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.enable = value;
    endtask

    function automatic vertex_t make_vertex(int kind, bit first);
        vertex_t vx;
        vx.first = first;
        case (kind)
            0: begin
                vx.px = POS_W'($urandom); vx.py = POS_W'($urandom);
                vx.pz = POS_W'($urandom);
                vx.tu = UV_W'($urandom); vx.tv = UV_W'($urandom);
            end
            1: begin
                vx.px = POS_W'($urandom_range(0, 2000) - 1000);
                vx.py = POS_W'($urandom_range(0, 2000) - 1000);
                vx.pz = POS_W'($urandom_range(0, 2000) - 1000);
                vx.tu = UV_W'($urandom_range(0, 64) - 32);
                vx.tv = UV_W'($urandom_range(0, 64) - 32);
            end
            default: begin
                vx.px = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
                vx.py = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
                vx.pz = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
                vx.tu = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                vx.tv = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            end
        endcase
        return vx;
    endfunction

    task automatic send_triangle(bit gaps, int kind);
        for (int k = 0; k < 3; k++)
            send_vertex(make_vertex(kind, k == 0), gaps);
    endtask

    function automatic vertex_t vtx(int x, int y, int z, int u, int v, bit f);
        vertex_t r;
        r.px = POS_W'(x); r.py = POS_W'(y); r.pz = POS_W'(z);
        r.tu = UV_W'(u); r.tv = UV_W'(v); r.first = f;
        return r;
    endfunction

    initial begin
        int kind;
        board.reset_state();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Unit right triangle, flipped det, zero det, zero-length, extremes.
        send_vertex(vtx(0, 0, 0, 0, 0, 1), 0);
        send_vertex(vtx(65536, 0, 0, 16384, 0, 0), 0);
        send_vertex(vtx(0, 65536, 0, 0, 16384, 0), 0);
        send_vertex(vtx(0, 0, 0, 0, 0, 1), 0);
        send_vertex(vtx(65536, 0, 0, 0, 16384, 0), 0);
        send_vertex(vtx(0, 65536, 0, 16384, 0, 0), 0);
        send_vertex(vtx(5, 6, 7, 100, 100, 1), 0);
        send_vertex(vtx(9, 1, 2, 200, 200, 0), 0);
        send_vertex(vtx(3, 3, 3, 300, 300, 0), 0);
        send_vertex(vtx(7, 7, 7, 0, 0, 1), 0);
        send_vertex(vtx(7, 7, 7, 16384, 0, 0), 0);
        send_vertex(vtx(7, 7, 7, 0, 16384, 0), 0);
        send_vertex(vtx(-8388608, -8388608, -8388608, -32768, -32768, 1), 0);
        send_vertex(vtx(8388607, 8388607, -8388608, 32767, -32768, 0), 0);
        send_vertex(vtx(-8388608, 8388607, 8388607, -32768, 32767, 0), 0);
        // Partial triangle dropped by a new first-vertex mark.
        send_vertex(vtx(1, 2, 3, 4, 5, 1), 0);
        send_vertex(vtx(6, 7, 8, 9, 10, 0), 0);
        send_vertex(vtx(0, 0, 0, 0, 0, 1), 0);
        send_vertex(vtx(-65536, 1000, 0, -16384, 50, 0), 0);
        send_vertex(vtx(300, -65536, 7, 90, -16384, 0), 0);

        write_enable(0);
        for (int t = 0; t < 20; t++) send_triangle(1, $urandom_range(0, 2));
        write_enable(1);

        // Backpressure: hold off the sink while vertices keep coming.
        long_hold = 6000;
        for (int t = 0; t < 8; t++) send_triangle(0, 1);
        wait_idle();

        sink_random = 1;
        while (vertices_sent < 1900) begin
            if ($urandom_range(0, 150) == 0) write_enable($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 60) == 0) wait_idle();
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                send_triangle($urandom_range(0, 4) != 0, kind < 4 ? 0 : kind < 7 ? 1 : 2);
            end else begin
                send_vertex(make_vertex($urandom_range(0, 1), $urandom_range(0, 1)), 1);
            end
        end
        write_enable(1);
        wait_idle();

        $display("Sent %0d vertices; checked %0d frames, %0d degenerate, enable toggled.",
                 vertices_sent, board.frames_seen, board.degenerate_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/ttf_pkg.sv
rtl/ttf_unit.sv
rtl/ttf_seq.sv
rtl/triangle_tangent_frame_core.sv
rtl/ttf_checker.sv
dv/triangle_tangent_frame_core_tb.sv
